@@ rtl/fob_pkg.sv @@
package fob_pkg;

    localparam int COORD_W  = 24;
    localparam int UNIT_W   = 16;
    localparam int RAD_W    = 25;
    localparam int CFG_IDX_W = 2;
    localparam int VEC_W    = 31;
    localparam int SUM_W    = 2 * VEC_W;
    localparam int ROOT_W   = 31;
    localparam int QUO_W    = 15;
    localparam int REM_W    = ROOT_W + 1;
    localparam int PROD_W   = 2 * UNIT_W;
    localparam int UNIT_LAT = ROOT_W + QUO_W + 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = CFG_IDX_W'(2);

    localparam logic [QUO_W-1:0] UNIT_ONE = QUO_W'(16384);

    typedef logic signed [VEC_W-1:0]  t_vec;
    typedef logic signed [UNIT_W-1:0] t_unit;
    typedef logic [ROOT_W-1:0]        t_root;

    typedef struct packed {
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_in_word;

    typedef struct packed {
        logic signed [UNIT_W-1:0] unit_normal_x;
        logic signed [UNIT_W-1:0] unit_normal_y;
        logic signed [UNIT_W-1:0] unit_normal_z;
        logic signed [UNIT_W-1:0] unit_radial_x;
        logic signed [UNIT_W-1:0] unit_radial_y;
        logic signed [UNIT_W-1:0] unit_radial_z;
        logic signed [UNIT_W-1:0] unit_binormal_x;
        logic signed [UNIT_W-1:0] unit_binormal_y;
        logic signed [UNIT_W-1:0] unit_binormal_z;
        logic [RAD_W-1:0]         radius;
    } t_out_word;

    function automatic logic [VEC_W-1:0] vec_mag(input t_vec v);
        logic [VEC_W-1:0] m;
        m = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        return m;
    endfunction

endpackage

@@ rtl/orthonormal_frame_builder.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+-------------------------------
// in       | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
// out      | o_out_valid / i_out_ready  | o_out_word (t_out_word)
// cfg      | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// One word per cycle while the output is not stalled. The pipeline is an input register,
// two root/divide units (31 root stages, 15 quotient stages each) with a
// cross-product stage pair between them.
// Synchronous active-low reset clears valid bits and the center registers.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module orthonormal_frame_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  fob_pkg::t_in_word                 i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output fob_pkg::t_out_word                o_out_word,
    input  logic                              i_cfg_we,
    input  logic [fob_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fob_pkg::COORD_W-1:0]       i_cfg_data
);
    import fob_pkg::*;

    localparam int SIDE_D = UNIT_LAT + 2;

    typedef struct packed {
        t_unit            nx;
        t_unit            ny;
        t_unit            nz;
        t_unit            rx;
        t_unit            ry;
        t_unit            rz;
        logic [RAD_W-1:0] rad;
    } t_side;

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic signed [COORD_W-1:0] r_center [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= '0;
            r_center[1] <= '0;
            r_center[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: radial difference
    logic signed [COORD_W-1:0] pt [3];
    logic signed [RAD_W-1:0]   diff [3];
    logic                      r_iv;
    t_vec                      r_nv [3];
    t_vec                      r_rv [3];

    always_comb begin
        pt[0] = i_in_word.point_x;
        pt[1] = i_in_word.point_y;
        pt[2] = i_in_word.point_z;
        for (int d = 0; d < 3; d++) begin
            diff[d] = pt[d] - r_center[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (en) begin
            r_iv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nv[0] <= VEC_W'(i_in_word.normal_x);
            r_nv[1] <= VEC_W'(i_in_word.normal_y);
            r_nv[2] <= VEC_W'(i_in_word.normal_z);
            for (int d = 0; d < 3; d++) begin
                r_rv[d] <= VEC_W'(diff[d]);
            end
        end
    end

    logic  n_ok;
    t_unit un [3];
    t_unit ur [3];
    t_root rlen;

    fob_unit u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_iv),
        .i_vec   (r_nv),
        .o_valid (n_ok),
        .o_unit  (un),
        .o_len   ()
    );

    fob_unit u_rad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_iv),
        .i_vec   (r_rv),
        .o_valid (),
        .o_unit  (ur),
        .o_len   (rlen)
    );

    // cross product
    logic                     r_cv1;
    logic signed [PROD_W-1:0] r_p [6];
    logic                     r_cv2;
    t_vec                     r_bv [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv1 <= 1'b0;
            r_cv2 <= 1'b0;
        end else if (en) begin
            r_cv1 <= n_ok;
            r_cv2 <= r_cv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0]  <= un[1] * ur[2];
            r_p[1]  <= un[2] * ur[1];
            r_p[2]  <= un[2] * ur[0];
            r_p[3]  <= un[0] * ur[2];
            r_p[4]  <= un[0] * ur[1];
            r_p[5]  <= un[1] * ur[0];
            r_bv[0] <= VEC_W'(r_p[0] - r_p[1]);
            r_bv[1] <= VEC_W'(r_p[2] - r_p[3]);
            r_bv[2] <= VEC_W'(r_p[4] - r_p[5]);
        end
    end

    logic  b_ok;
    t_unit ub [3];

    fob_unit u_bin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_cv2),
        .i_vec   (r_bv),
        .o_valid (b_ok),
        .o_unit  (ub),
        .o_len   ()
    );

    // normal, radial and radius wait for the binormal
    t_side r_side [SIDE_D];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{nx: un[0], ny: un[1], nz: un[2],
                           rx: ur[0], ry: ur[1], rz: ur[2],
                           rad: rlen[RAD_W-1:0]};
            for (int k = 1; k < SIDE_D; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_out_valid = b_ok;

    always_comb begin
        o_out_word.unit_normal_x   = r_side[SIDE_D-1].nx;
        o_out_word.unit_normal_y   = r_side[SIDE_D-1].ny;
        o_out_word.unit_normal_z   = r_side[SIDE_D-1].nz;
        o_out_word.unit_radial_x   = r_side[SIDE_D-1].rx;
        o_out_word.unit_radial_y   = r_side[SIDE_D-1].ry;
        o_out_word.unit_radial_z   = r_side[SIDE_D-1].rz;
        o_out_word.unit_binormal_x = ub[0];
        o_out_word.unit_binormal_y = ub[1];
        o_out_word.unit_binormal_z = ub[2];
        o_out_word.radius          = r_side[SIDE_D-1].rad;
    end

endmodule

@@ rtl/fob_unit.sv @@
module fob_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  fob_pkg::t_vec  i_vec [3],
    output logic           o_valid,
    output fob_pkg::t_unit o_unit [3],
    output fob_pkg::t_root o_len
);
    import fob_pkg::*;

    localparam int TW = SUM_W + 1;

    // squares
    logic             r_va;
    t_vec             r_vec_a [3];
    logic [SUM_W-1:0] r_sq [3];
    logic [VEC_W-1:0] mag_in [3];
    logic [SUM_W-1:0] sq [3];

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            mag_in[d] = vec_mag(i_vec[d]);
            sq[d]     = mag_in[d] * mag_in[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec_a <= i_vec;
            r_sq    <= sq;
        end
    end

    // sum of squares feeds the root pipeline
    logic             r_sv   [ROOT_W+1];
    logic [SUM_W-1:0] r_rem  [ROOT_W+1];
    t_root            r_q    [ROOT_W+1];
    t_vec             r_svec [ROOT_W+1][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_q[0]    <= '0;
            r_svec[0] <= r_vec_a;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;
        logic [TW-1:0] trial;
        logic          take;

        assign trial = (TW'(r_q[k]) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = {1'b0, r_rem[k]} >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (i_en) begin
                r_sv[k+1] <= r_sv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= take ? SUM_W'({1'b0, r_rem[k]} - trial) : r_rem[k];
                r_q[k+1]    <= take ? (r_q[k] | (ROOT_W'(1) << B)) : r_q[k];
                r_svec[k+1] <= r_svec[k];
            end
        end
    end

    // one quotient bit per stage
    logic             r_dv   [1:QUO_W];
    t_root            r_dlen [1:QUO_W];
    logic [REM_W-1:0] r_drem [1:QUO_W][3];
    logic [QUO_W-1:0] r_dq   [1:QUO_W][3];
    logic             r_dneg [1:QUO_W][3];

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic             in_v;
        t_root            in_len;
        logic [REM_W-1:0] in_rem [3];
        logic [QUO_W-1:0] in_q   [3];
        logic             in_neg [3];
        logic [REM_W-1:0] sh     [3];
        logic             qb     [3];
        logic [REM_W-1:0] n_rem  [3];
        logic [QUO_W-1:0] n_q    [3];

        if (j == 0) begin : g_seed
            always_comb begin
                in_v   = r_sv[ROOT_W];
                in_len = r_q[ROOT_W];
                for (int d = 0; d < 3; d++) begin
                    in_rem[d] = REM_W'(vec_mag(r_svec[ROOT_W][d]));
                    in_q[d]   = '0;
                    in_neg[d] = r_svec[ROOT_W][d][VEC_W-1];
                end
            end
        end else begin : g_link
            always_comb begin
                in_v   = r_dv[j];
                in_len = r_dlen[j];
                for (int d = 0; d < 3; d++) begin
                    in_rem[d] = r_drem[j][d];
                    in_q[d]   = r_dq[j][d];
                    in_neg[d] = r_dneg[j][d];
                end
            end
        end

        always_comb begin
            for (int d = 0; d < 3; d++) begin
                sh[d]    = (j == 0) ? in_rem[d] : {in_rem[d][REM_W-2:0], 1'b0};
                qb[d]    = sh[d] >= REM_W'(in_len);
                n_rem[d] = qb[d] ? sh[d] - REM_W'(in_len) : sh[d];
                n_q[d]   = {in_q[d][QUO_W-2:0], qb[d]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[j+1] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dlen[j+1] <= in_len;
                r_drem[j+1] <= n_rem;
                r_dq[j+1]   <= n_q;
                r_dneg[j+1] <= in_neg;
            end
        end
    end

    // clamp, sign, zero length
    logic             r_ov;
    t_unit            r_unit [3];
    t_root            r_len;
    logic [UNIT_W-1:0] mg [3];

    always_comb begin
        for (int d = 0; d < 3; d++) begin
            mg[d] = UNIT_W'((r_dq[QUO_W][d] > UNIT_ONE) ? UNIT_ONE : r_dq[QUO_W][d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len <= r_dlen[QUO_W];
            for (int d = 0; d < 3; d++) begin
                if (r_dlen[QUO_W] == '0) begin
                    r_unit[d] <= '0;
                end else if (r_dneg[QUO_W][d]) begin
                    r_unit[d] <= $signed(UNIT_W'(0) - mg[d]);
                end else begin
                    r_unit[d] <= $signed(mg[d]);
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_unit  = r_unit;
    assign o_len   = r_len;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import fob_pkg::*;

    localparam int PIPE_LAT   = 101;
    localparam int STALL_LIM  = 5000;
    localparam int HOLD_LEN   = 400;
    localparam int N_RANDOM   = 220;

    localparam logic [CFG_IDX_W-1:0] IDX_NONE = 2'd3;

    localparam logic signed [COORD_W-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 24'sh800000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [COORD_W-1:0]    i_cfg_data;

    orthonormal_frame_builder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    logic signed [COORD_W-1:0] center [3];
    t_out_word  frame_q [$];
    int         err_cnt;
    int         words_in;
    int         words_out;
    int         burst_left;
    int         idle_cycles;
    bit         hold_req;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned to_unit(input longint vx, vy, vz,
                                                output longint ux, uy, uz);
        longint unsigned len;
        longint q [3];
        longint v [3];
        v = '{vx, vy, vz};
        len = floor_root(longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz));
        for (int d = 0; d < 3; d++) begin
            if (len == 0) begin
                q[d] = 0;
            end else begin
                q[d] = (v[d] * 16384) / longint'(len);
                if (q[d] > 16384) q[d] = 16384;
                if (q[d] < -16384) q[d] = -16384;
            end
        end
        ux = q[0];
        uy = q[1];
        uz = q[2];
        return len;
    endfunction

    function automatic t_out_word build_frame(input t_in_word w);
        t_out_word f;
        longint nx, ny, nz, rx, ry, rz, bx, by, bz;
        longint unsigned rad, dummy;
        dummy = to_unit(longint'(w.normal_x), longint'(w.normal_y), longint'(w.normal_z),
                        nx, ny, nz);
        rad = to_unit(longint'(w.point_x) - longint'(center[0]),
                      longint'(w.point_y) - longint'(center[1]),
                      longint'(w.point_z) - longint'(center[2]), rx, ry, rz);
        dummy = to_unit(ny * rz - nz * ry, nz * rx - nx * rz, nx * ry - ny * rx,
                        bx, by, bz);
        f.unit_normal_x   = UNIT_W'(nx);
        f.unit_normal_y   = UNIT_W'(ny);
        f.unit_normal_z   = UNIT_W'(nz);
        f.unit_radial_x   = UNIT_W'(rx);
        f.unit_radial_y   = UNIT_W'(ry);
        f.unit_radial_z   = UNIT_W'(rz);
        f.unit_binormal_x = UNIT_W'(bx);
        f.unit_binormal_y = UNIT_W'(by);
        f.unit_binormal_z = UNIT_W'(bz);
        f.radius          = RAD_W'(rad);
        return f;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (word %0d)", what, got, want, words_out);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            frame_q.push_back(build_frame(i_in_word));
            words_in++;
        end
    end

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frame_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                e = frame_q.pop_front();
                if (o_out_word.unit_normal_x != e.unit_normal_x)
                    report_mismatch("unit_normal_x", o_out_word.unit_normal_x, e.unit_normal_x);
                if (o_out_word.unit_normal_y != e.unit_normal_y)
                    report_mismatch("unit_normal_y", o_out_word.unit_normal_y, e.unit_normal_y);
                if (o_out_word.unit_normal_z != e.unit_normal_z)
                    report_mismatch("unit_normal_z", o_out_word.unit_normal_z, e.unit_normal_z);
                if (o_out_word.unit_radial_x != e.unit_radial_x)
                    report_mismatch("unit_radial_x", o_out_word.unit_radial_x, e.unit_radial_x);
                if (o_out_word.unit_radial_y != e.unit_radial_y)
                    report_mismatch("unit_radial_y", o_out_word.unit_radial_y, e.unit_radial_y);
                if (o_out_word.unit_radial_z != e.unit_radial_z)
                    report_mismatch("unit_radial_z", o_out_word.unit_radial_z, e.unit_radial_z);
                if (o_out_word.unit_binormal_x != e.unit_binormal_x)
                    report_mismatch("unit_binormal_x", o_out_word.unit_binormal_x,
                                    e.unit_binormal_x);
                if (o_out_word.unit_binormal_y != e.unit_binormal_y)
                    report_mismatch("unit_binormal_y", o_out_word.unit_binormal_y,
                                    e.unit_binormal_y);
                if (o_out_word.unit_binormal_z != e.unit_binormal_z)
                    report_mismatch("unit_binormal_z", o_out_word.unit_binormal_z,
                                    e.unit_binormal_z);
                if (o_out_word.radius != e.radius)
                    report_mismatch("radius", o_out_word.radius, e.radius);
            end
            words_out++;
        end
    end

    // receiver: random stall pattern, plus a long hold-off on request
    always @(posedge i_clk) begin
        int hold_cnt;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt = 0;
        end else if (hold_req) begin
            i_out_ready <= 1'b0;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) begin
                hold_req = 1'b0;
                hold_cnt = 0;
            end
        end else if (words_in % 200 < 60) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIM) begin
                $display("timeout with %0d words outstanding", frame_q.size());
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic send_word(input t_in_word w);
        if (burst_left == 0) begin
            int gap;
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (frame_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 8) @(posedge i_clk);
    endtask

    task automatic write_center(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx != IDX_NONE) center[idx] = val;
    endtask

    function automatic t_in_word make_word(input logic [COORD_W-1:0] nx, ny, nz, px, py, pz);
        t_in_word w;
        w.normal_x = nx;
        w.normal_y = ny;
        w.normal_z = nz;
        w.point_x  = px;
        w.point_y  = py;
        w.point_z  = pz;
        return w;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return COORD_W'($urandom_range(0, 64)) - 24'd32;
            1: return C_MAX - COORD_W'($urandom_range(0, 3));
            2: return C_MIN + COORD_W'($urandom_range(0, 3));
            3: return COORD_W'($urandom_range(0, 8191)) - 24'd4096;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int sel;
        logic signed [COORD_W-1:0] k;
        w = make_word(rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord());
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            w.normal_x = 0; w.normal_y = 0; w.normal_z = 0;
        end else if (sel == 1) begin
            w.point_x = center[0]; w.point_y = center[1]; w.point_z = center[2];
        end else if (sel == 2) begin
            // radial parallel to the normal, or zero when k is zero
            k = COORD_W'($urandom_range(1, 8)) - 24'd4;
            w.normal_x = COORD_W'($urandom_range(0, 2000)) - 24'd1000;
            w.normal_y = COORD_W'($urandom_range(0, 2000)) - 24'd1000;
            w.normal_z = COORD_W'($urandom_range(0, 2000)) - 24'd1000;
            w.point_x = center[0] + w.normal_x * k;
            w.point_y = center[1] + w.normal_y * k;
            w.point_z = center[2] + w.normal_z * k;
        end
        return w;
    endfunction

    task automatic test_directed();
        send_word(make_word(0, 0, 0, 0, 0, 0));
        send_word(make_word(0, 0, 0, 24'd4096, 0, 0));
        send_word(make_word(24'd4096, 0, 0, 0, 0, 0));
        send_word(make_word(24'd4096, 0, 0, 24'd8192, 0, 0));
        send_word(make_word(24'd4096, 0, 0, 0, 24'd4096, 0));
        send_word(make_word(0, 24'd1, 0, 0, 0, 24'd1));
        send_word(make_word(24'd1, 24'd1, 0, 24'd1, 24'd1, 24'd1));
        send_word(make_word(24'd1, -24'sd1, 24'd1, -24'sd1, 24'd1, 24'd1));
        send_word(make_word(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX));
        send_word(make_word(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_word(make_word(C_MAX, C_MIN, 0, C_MIN, C_MAX, C_MAX));
        send_word(make_word(C_MIN, 0, 0, 0, C_MIN, 0));
        send_word(make_word(0, 0, C_MAX, C_MAX, 0, 0));
        send_word(make_word(-24'sd3, 24'd7, 24'd2, C_MIN, 0, C_MAX));
        send_word(make_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'h0F0F0F));
        drain();
    endtask

    task automatic test_centers();
        logic [COORD_W-1:0] sets [4][3];
        sets = '{'{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN},
                 '{C_MAX, C_MIN, 24'd0}, '{24'd4096, -24'sd8192, 24'd12}};
        for (int s = 0; s < 4; s++) begin
            write_center(CFG_CENTER_X, sets[s][0]);
            write_center(CFG_CENTER_Y, sets[s][1]);
            write_center(CFG_CENTER_Z, sets[s][2]);
            write_center(IDX_NONE, COORD_W'($urandom));
            send_word(make_word(24'd4096, 0, 0, center[0], center[1], center[2]));
            send_word(make_word(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN));
            send_word(make_word(C_MIN, 24'd1, 0, C_MAX, C_MAX, C_MAX));
            for (int i = 0; i < 60; i++) send_word(rand_word());
            drain();
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < N_RANDOM / 2; i++) begin
            if (i % 100 == 50) begin
                drain();
                write_center(CFG_CENTER_X, rand_coord());
                write_center(CFG_CENTER_Y, rand_coord());
                write_center(CFG_CENTER_Z, rand_coord());
            end
            send_word(rand_word());
        end
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 160; i++) send_word(rand_word());
        drain();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        center     = '{0, 0, 0};
        err_cnt    = 0;
        words_in   = 0;
        words_out  = 0;
        burst_left = 0;
        hold_req   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_centers();
        test_backpressure();
        test_random();
        write_center(CFG_CENTER_X, 0);
        write_center(CFG_CENTER_Y, 0);
        write_center(CFG_CENTER_Z, 0);
        test_random();
        $display("covered: %0d words in, %0d frames checked, %0d mismatches", words_in,
                 words_out, err_cnt);
        $display("center extremes, ignored index, output hold-off and random stalls exercised");
        if (err_cnt == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fob_pkg.sv
rtl/fob_unit.sv
rtl/orthonormal_frame_builder.sv
test/tb_top.sv
